### sv/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII unit.
// No dependencies.
package sitda_pkg;

	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned CHAR_W      = 8;
	localparam int unsigned DIGIT_W     = 4;
	localparam int unsigned MAX_DIGITS  = 10;
	localparam int unsigned CNT_W       = 4;
	localparam int unsigned PROD_W      = 2 * VALUE_W;
	// floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
	localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam int unsigned        RECIP_SHIFT = 35;
	localparam int unsigned        QUOT_W      = PROD_W - RECIP_SHIFT;

	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
	localparam logic [CNT_W-1:0]   LAST_CNT   = 4'd1;
	localparam logic [CNT_W-1:0]   FULL_CNT   = CNT_W'(MAX_DIGITS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_first;
		logic div_step;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic neg;
		logic div_done;
		logic last_digit;
		logic out_free;
	} status_t;

endpackage

### sv/sitda_ctrl.sv
// Controller state machine for the decimal ASCII unit.
// Depends on sitda_pkg; drives the datapath through cmd_t, reads status_t.
module sitda_ctrl import sitda_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    value_valid,
	output logic    value_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		cmd         = '0;
		value_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				value_stall = 1'b0;
				if (value_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_first = 1'b1;
				state_nxt     = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					state_nxt = status.neg ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (status.out_free) begin
					cmd.emit_sign = 1'b1;
					state_nxt     = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit_digit = 1'b1;
					// final digit leaves the unit free for the next item
					if (status.last_digit) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

### sv/sitda_dpath.sv
// Datapath of the decimal ASCII unit: magnitude, reciprocal multiplier,
// digit buffer and output register. Depends on sitda_pkg.
module sitda_dpath import sitda_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output status_t                   status,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      char_valid,
	input  logic                      char_stall,
	output logic [CHAR_W-1:0]         char_code,
	output logic                      is_last
);

	logic [VALUE_W-1:0] mag_q;
	logic [PROD_W-1:0]  prod_q;
	logic               neg_q;
	logic [CNT_W-1:0]   ndig_q;
	logic [DIGIT_W-1:0] dig_q [MAX_DIGITS];
	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	logic [VALUE_W-1:0] abs_val;
	logic [VALUE_W-1:0] quot;
	logic [VALUE_W-1:0] quot_x10;
	logic [VALUE_W-1:0] rem_full;
	logic [VALUE_W-1:0] mul_in;
	logic [CNT_W-1:0]   rd_idx;
	logic               out_free;

	assign abs_val  = value[VALUE_W-1] ? (~value + 1'b1) : value;
	assign quot     = VALUE_W'(prod_q[PROD_W-1:RECIP_SHIFT]);
	assign quot_x10 = {quot[VALUE_W-4:0], 3'b000} + {quot[VALUE_W-2:0], 1'b0};
	assign rem_full = mag_q - quot_x10;
	assign mul_in   = cmd.mul_first ? mag_q : quot;
	assign rd_idx   = ndig_q - 1'b1;
	assign out_free = !out_valid_q || !char_stall;

	assign status.neg        = neg_q;
	assign status.div_done   = (quot == '0) || (ndig_q == FULL_CNT);
	assign status.last_digit = (ndig_q == LAST_CNT);
	assign status.out_free   = out_free;

	// magnitude and quotient chain: one digit per cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= abs_val;
			neg_q <= value[VALUE_W-1];
		end else if (cmd.div_step) begin
			mag_q <= quot;
		end
		if (cmd.mul_first || cmd.div_step) begin
			prod_q <= PROD_W'(mul_in) * PROD_W'(RECIP_TEN);
		end
		if (cmd.div_step) begin
			dig_q[ndig_q] <= rem_full[DIGIT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ndig_q <= '0;
		end else if (cmd.load) begin
			ndig_q <= '0;
		end else if (cmd.div_step) begin
			ndig_q <= ndig_q + 1'b1;
		end else if (cmd.emit_digit) begin
			ndig_q <= rd_idx;
		end
	end

	// output register: holds an item until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (!char_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= CHAR_ZERO + CHAR_W'(dig_q[rd_idx]);
			last_q <= (ndig_q == LAST_CNT);
		end
	end

	assign char_valid = out_valid_q;
	assign char_code  = char_q;
	assign is_last    = last_q;

endmodule

### sv/signed_int_to_decimal_ascii_unit.sv
// Signed 32-bit integer to decimal ASCII text. Each item on the value channel
// yields 1 to 11 character items, most significant first: a '-' for negative
// values, then the digits with no leading zeros, the final digit marked by
// is_last. Digits are peeled off one per cycle by a reciprocal multiply by
// 1/10 into a ten-entry buffer, then sent one per cycle through a single
// output register while the receiver does not stall. A new value is taken
// while the last character still waits in the output register.
// Depends on sitda_pkg, sitda_ctrl and sitda_dpath.
module signed_int_to_decimal_ascii_unit import sitda_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      value_valid,
	output logic                      value_stall,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      char_valid,
	input  logic                      char_stall,
	output logic [CHAR_W-1:0]         char_code,
	output logic                      is_last
);

	cmd_t    cmd;
	status_t status;

	sitda_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.status      (status),
		.cmd         (cmd)
	);

	sitda_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.value      (value),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code),
		.is_last    (is_last)
	);

endmodule

### sv/sitda_checker.sv
// Port-level checks for the decimal ASCII unit, bound to the top level.
// Depends on sitda_pkg and signed_int_to_decimal_ascii_unit.
module sitda_checker import sitda_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      value_valid,
	input logic                      value_stall,
	input logic signed [VALUE_W-1:0] value,
	input logic                      char_valid,
	input logic                      char_stall,
	input logic [CHAR_W-1:0]         char_code,
	input logic                      is_last
);

	// one item at a time: an accepted item blocks the input next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid && !value_stall |=> value_stall)
		else $error("input taken on two cycles in a row");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid && value_stall |=> value_valid && $stable(value))
		else $error("stalled input item changed");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && (char_code == CHAR_MINUS) |-> !is_last)
		else $error("sign character marked last");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (char_code == CHAR_MINUS) ||
			((char_code >= CHAR_ZERO) && (char_code <= CHAR_ZERO + 8'd9)))
		else $error("character outside '-' and digits");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_stall |=>
			char_valid && $stable(char_code) && $stable(is_last))
		else $error("stalled output item changed");

endmodule

bind signed_int_to_decimal_ascii_unit sitda_checker u_sitda_checker (.*);

### sim/tb.sv
// Testbench for signed_int_to_decimal_ascii_unit: random and corner integers in, decimal
// characters out, checked against a scoreboard that predicts the text of each value.
// Depends on sitda_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb;
	import sitda_pkg::*;

	localparam int RANDOM_ITEMS = 240;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 40;

	typedef struct {
		logic [CHAR_W-1:0] code;
		logic              last;
	} char_item_t;

	class decimal_text_board;
		char_item_t expected_chars[$];
		int         errors;

		function new();
			errors = 0;
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= 10)
				$display("%t: %s", $realtime, what);
		endfunction

		// Queue the characters that the decimal text of v is made of.
		function void note_value(logic signed [VALUE_W-1:0] v);
			logic [VALUE_W-1:0] mag;
			logic [DIGIT_W-1:0] digits[$];
			char_item_t         ch;
			mag = v;
			if (v[VALUE_W-1]) begin
				mag = ~mag + 1'b1;
				ch.code = CHAR_MINUS;
				ch.last = 1'b0;
				expected_chars.push_back(ch);
			end
			do begin
				digits.push_front(DIGIT_W'(mag % 10));
				mag = mag / 10;
			end while (mag != 0);
			foreach (digits[i]) begin
				ch.code = CHAR_ZERO + CHAR_W'(digits[i]);
				ch.last = (i == digits.size() - 1);
				expected_chars.push_back(ch);
			end
		endfunction

		function void check_char(logic [CHAR_W-1:0] code, logic last);
			char_item_t want;
			if (expected_chars.size() == 0) begin
				flag($sformatf("unexpected char %0d is_last %0b", code, last));
				return;
			end
			want = expected_chars.pop_front();
			if (code !== want.code || last !== want.last)
				flag($sformatf("char mismatch: expected %0d is_last %0b, got %0d is_last %0b",
					want.code, want.last, code, last));
		endfunction
	endclass

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      value_valid = 1'b0;
	logic                      value_stall;
	logic signed [VALUE_W-1:0] value       = '0;
	logic                      char_valid;
	logic                      char_stall  = 1'b0;
	logic [CHAR_W-1:0]         char_code;
	logic                      is_last;

	decimal_text_board book = new();
	bit                hold_wanted = 1'b0;

	signed_int_to_decimal_ascii_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.value_valid(value_valid),
		.value_stall(value_stall),
		.value      (value),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code),
		.is_last    (is_last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && value_valid && !value_stall)
			book.note_value(value);
		if (arst_n && char_valid && !char_stall)
			book.check_char(char_code, is_last);
	end

	// Offer one item from a falling edge and hold it until it is taken.
	task automatic send_value(input logic signed [VALUE_W-1:0] v);
		value_valid <= 1'b1;
		value       <= v;
		do @(posedge clk); while (value_stall);
		@(negedge clk);
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			value_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	function automatic logic signed [VALUE_W-1:0] random_value();
		longint mag;
		longint pow;
		int     k;
		pow = 1;
		k = $urandom_range(1, 10);
		repeat (k) pow = pow * 10;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: mag = $urandom_range(0, 99);
			2: mag = pow / 10 + $urandom_range(0, 2) - 1;
			default: mag = {$urandom, $urandom} % pow;
		endcase
		if (mag > 64'sd2147483648)
			mag = 64'sd2147483648;
		if ($urandom_range(0, 1))
			mag = -mag;
		return VALUE_W'(mag);
	endfunction

	// Receiver: stall in runs of changing density, and hold off once for a long stretch.
	initial begin
		int  mode;
		int  run;
		bit  held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_wanted && !held) begin
				held = 1'b1;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					char_stall <= 1'b1;
				end
			end
			mode = $urandom_range(0, 3);
			run  = $urandom_range(10, 60);
			repeat (run) begin
				@(negedge clk);
				case (mode)
					0: char_stall <= 1'b0;
					1: char_stall <= ($urandom_range(0, 3) == 0);
					2: char_stall <= $urandom_range(0, 1);
					default: char_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin
		logic signed [VALUE_W-1:0] corners[$];
		int                        sent;
		int                        burst;
		corners = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001, 32'sd1000000000,
			32'sd999999999, -32'sd1000000000, 32'sd1234567890, -32'sd987654321,
			32'sd7, -32'sd5, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd2147483640};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (corners[i]) begin
			send_value(corners[i]);
			if ($urandom_range(0, 2) == 0)
				idle_cycles($urandom_range(1, 6));
		end

		hold_wanted = 1'b1;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				send_value(random_value());
				sent++;
			end
			idle_cycles($urandom_range(0, 15));
		end
		value_valid <= 1'b0;

		while (book.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (book.pending() != 0)
			book.flag($sformatf("%0d characters never arrived", book.pending()));
		if (book.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
